/* design/oggpcs_pkg.sv */
// ----------------------------------------------------------------------------
// Ogg page codec sniffer package
// Shared constants, signature tables and types for the sniffer modules.
// ----------------------------------------------------------------------------
package oggpcs_pkg;

  localparam int unsigned PosW      = 9;
  localparam int unsigned SegW      = 8;
  localparam int unsigned FmtW      = 3;
  localparam int unsigned SigCount  = 3;
  localparam int unsigned SigMaxLen = 8;

  localparam logic [PosW-1:0] HdrBytes = 9'd27;
  localparam logic [PosW-1:0] SegPos   = 9'd26;
  localparam logic [PosW-1:0] CapLen   = 9'd4;
  localparam logic [PosW-1:0] PosMax   = 9'd511;

  localparam logic [FmtW-1:0] FmtOggFlac   = 3'd3;
  localparam logic [FmtW-1:0] FmtOggVorbis = 3'd4;
  localparam logic [FmtW-1:0] FmtOggOpus   = 3'd5;

  // "OggS"
  localparam logic [7:0] CapPattern [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

  // 0x7F "FLAC", 0x01 "vorbis", "OpusHead"
  localparam logic [7:0] SigBytes [SigCount][SigMaxLen] = '{
    '{8'h7F, 8'h46, 8'h4C, 8'h41, 8'h43, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h76, 8'h6F, 8'h72, 8'h62, 8'h69, 8'h73, 8'h00},
    '{8'h4F, 8'h70, 8'h75, 8'h73, 8'h48, 8'h65, 8'h61, 8'h64}
  };
  localparam logic [PosW-1:0] SigLen [SigCount] = '{9'd5, 9'd7, 9'd8};
  localparam logic [FmtW-1:0] SigFormat [SigCount] = '{FmtOggFlac, FmtOggVorbis, FmtOggOpus};

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

endpackage

/* design/oggpcs_in_if.sv */
// ----------------------------------------------------------------------------
// Ogg sniffer byte channel
// Valid/ready channel carrying one page byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface oggpcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/oggpcs_out_if.sv */
// ----------------------------------------------------------------------------
// Ogg sniffer result channel
// Valid/ready channel carrying one detected stream format code.
// ----------------------------------------------------------------------------
interface oggpcs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] stream_format;

  modport source (output valid, output stream_format, input ready);
  modport sink (input valid, input stream_format, output ready);
endinterface

/* design/oggpcs_cfg_if.sv */
// ----------------------------------------------------------------------------
// Ogg sniffer configuration channel
// Valid/ready write channel for the fallback format register.
// ----------------------------------------------------------------------------
interface oggpcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] fallback_format;

  modport source (output valid, output fallback_format, input ready);
  modport sink (input valid, input fallback_format, output ready);
endinterface

/* design/ogg_page_codec_sniffer_top.sv */
// ----------------------------------------------------------------------------
// Ogg page codec sniffer
// Identifies the codec of a buffered Ogg page from its header and body.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   takes the page one byte per request; last_byte marks the final
//          byte of the buffer. One byte is accepted every cycle, except while a last byte is held (see Stall).
//   out_o  gives exactly one stream_format per page, after the last byte:
//          the matched codec (3 ogg flac, 4 ogg vorbis, 5 ogg opus) or the
//          fallback format when the page is short, lacks "OggS", has an
//          empty body or carries no known signature.
//   cfg_i  writes the fallback format; always ready, write it while idle.
// Result path: the last byte sits in the input register until the scan stage
//   takes it, and the edge that takes it loads the result register.
// Throughput: one byte per cycle while no last byte is held in the input register.
// Stall: while a result waits on out_o, non-final bytes of the next page
//   still flow; the next last byte holds in the input register until the
//   result is taken.
// Reset: clears the scan state and the fallback format to 0; the
//   scan state also clears by itself after every last byte.
// ----------------------------------------------------------------------------
module ogg_page_codec_sniffer_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  oggpcs_in_if.sink    in_i,
  oggpcs_cfg_if.sink   cfg_i,
  oggpcs_out_if.source out_o
);
  import oggpcs_pkg::*;

  in_item_t        item;
  logic            advance;
  logic [FmtW-1:0] fallback_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= '0;
    end else if (cfg_i.valid) begin
      fallback_q <= cfg_i.fallback_format;
    end
  end

  oggpcs_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .advance_i   (advance),
    .ready_o     (in_i.ready),
    .item_o      (item)
  );

  oggpcs_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .fallback_i      (fallback_q),
    .out_ready_i     (out_o.ready),
    .advance_o       (advance),
    .out_valid_o     (out_o.valid),
    .stream_format_o (out_o.stream_format)
  );

`ifndef ASSERT_OFF
  // Input back-pressure only comes from a held last byte behind a full result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (item.valid && item.last_byte && out_o.valid && !out_o.ready))
    else $error("input stalled without a blocked result");

  // A new result only follows a last byte leaving the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(item.valid && item.last_byte && advance))
    else $error("result raised without a last byte");

  // A non-final byte never waits in the input register.
  a_mid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item.valid && !item.last_byte) |-> advance)
    else $error("non-final byte held in input register");
`endif
endmodule

/* design/oggpcs_in_reg.sv */
// ----------------------------------------------------------------------------
// Ogg sniffer input register
// Captures one byte request and holds it until the scan stage takes it.
// ----------------------------------------------------------------------------
module oggpcs_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic                advance_i,
  output logic                ready_o,
  output oggpcs_pkg::in_item_t item_o
);
  import oggpcs_pkg::*;

  in_item_t item_q, item_d;

  assign ready_o = !item_q.valid || advance_i;

  always_comb begin
    item_d = item_q;
    if (ready_o) begin
      item_d.valid     = valid_i;
      item_d.data_byte = data_byte_i;
      item_d.last_byte = last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;
endmodule

/* design/oggpcs_scan.sv */
// ----------------------------------------------------------------------------
// Ogg sniffer scan stage
// Tracks page position, capture pattern, segment count and signature
// matches; registers the format verdict on the last byte.
// ----------------------------------------------------------------------------
module oggpcs_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oggpcs_pkg::in_item_t item_i,
  input  logic [2:0]          fallback_i,
  input  logic                out_ready_i,
  output logic                advance_o,
  output logic                out_valid_o,
  output logic [2:0]          stream_format_o
);
  import oggpcs_pkg::*;

  logic [PosW-1:0]     pos_q, pos_d;
  logic                cap_q, cap_d;
  logic [SegW-1:0]     seg_q, seg_d;
  logic [SigCount-1:0] alive_q, alive_d;
  logic                out_valid_q;
  logic [FmtW-1:0]     fmt_q, fmt_d;

  logic [PosW:0]       body_start;
  logic [PosW:0]       off_wide;
  logic [PosW-1:0]     off;
  logic                in_body;
  logic                found;

  // A last byte waits while the result register is still full.
  assign advance_o = item_i.valid &&
                     (!item_i.last_byte || !out_valid_q || out_ready_i);

  assign body_start = {1'b0, HdrBytes} + {{(PosW+1-SegW){1'b0}}, seg_q};
  assign in_body    = {1'b0, pos_q} >= body_start;
  assign off_wide   = {1'b0, pos_q} - body_start;
  assign off        = off_wide[PosW-1:0];

  always_comb begin
    cap_d   = cap_q;
    seg_d   = seg_q;
    alive_d = alive_q;
    if (pos_q < CapLen) begin
      if (item_i.data_byte != CapPattern[pos_q[1:0]]) begin
        cap_d = 1'b0;
      end
    end else if (pos_q == SegPos) begin
      seg_d = item_i.data_byte;
    end else if (in_body) begin
      for (int i = 0; i < SigCount; i++) begin
        if (off < SigLen[i] && item_i.data_byte != SigBytes[i][off[2:0]]) begin
          alive_d[i] = 1'b0;
        end
      end
    end
  end

  // Pick the first signature that survived over its whole length.
  always_comb begin
    fmt_d = fallback_i;
    found = 1'b0;
    if (in_body && cap_q) begin
      for (int i = 0; i < SigCount; i++) begin
        if (!found && alive_d[i] && off >= SigLen[i] - 9'd1) begin
          fmt_d = SigFormat[i];
          found = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cap_q       <= 1'b1;
      seg_q       <= '0;
      alive_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        if (item_i.last_byte) begin
          pos_q   <= '0;
          cap_q   <= 1'b1;
          seg_q   <= '0;
          alive_q <= '1;
        end else begin
          if (pos_q != PosMax) begin
            pos_q <= pos_q + 9'd1;
          end
          cap_q   <= cap_d;
          seg_q   <= seg_d;
          alive_q <= alive_d;
        end
      end
      if (advance_o && item_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && item_i.last_byte) begin
      fmt_q <= fmt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stream_format_o = fmt_q;
endmodule
